// File: rtl/nsc_pkg.sv
package nsc_pkg;

    // Longest line, newline included, before the line is flagged as overflow.
    localparam int unsigned MAX_LINE = 512;

    // Width of the line length field of a result.
    localparam int unsigned LEN_W = 10;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LINE);

    // Width of the packed result on the output stream, padded to whole bytes.
    localparam int unsigned RES_W = 1 + 3 + 8 + 8 + LEN_W;
    localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8;

    // Verdict codes.
    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_NODOLLAR = 3'd1;
    localparam t_status ST_NOSTAR   = 3'd2;
    localparam t_status ST_BADHEX   = 3'd3;
    localparam t_status ST_MISMATCH = 3'd4;
    localparam t_status ST_OVERFLOW = 3'd5;

    // Characters that frame a sentence.
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // One verdict; the last member sits in the lowest bits.
    typedef struct packed {
        logic [LEN_W-1:0] line_length;
        logic [7:0]       received_sum;
        logic [7:0]       computed_sum;
        t_status          status;
        logic             line_ok;
    } t_result;

endpackage

// File: rtl/nsc_in_stage.sv
module nsc_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    output logic       o_ready,
    input  logic       i_adv,
    output logic       o_valid,
    output logic [7:0] o_data
);
    import nsc_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;

    // The register takes a new byte when it is empty or its byte moves on.
    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/nsc_line_check.sv
module nsc_line_check (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data,
    input  logic            i_out_free,
    output logic            o_adv,
    output logic            o_fire,
    output nsc_pkg::t_result o_result
);
    import nsc_pkg::*;

    // Line phases.
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_BODY  = 3'd1;
    localparam logic [2:0] PH_HEX1  = 3'd2;
    localparam logic [2:0] PH_HEX2  = 3'd3;
    localparam logic [2:0] PH_TAIL  = 3'd4;
    localparam logic [2:0] PH_ERR   = 3'd5;

    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_sum, n_sum;
    t_status          r_err, n_err;
    logic [LEN_W-1:0] r_cnt, n_cnt;

    logic       is_nl;
    logic       cnt_sat;
    logic [2:0] ph_eff;
    t_status    err_eff;
    logic [4:0] hex;
    t_status    status;

    // Decode an uppercase hex digit: bit 4 flags a byte that is not one.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b0, c[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = {1'b0, c[3:0] + 4'd9};
        end else begin
            d = 5'h10;
        end
        return d;
    endfunction

    assign is_nl = (i_data == CH_NEWLINE);

    // A newline waits only while the result register is still held.
    assign o_adv  = i_valid && (!is_nl || i_out_free);
    assign o_fire = o_adv && is_nl;

    // The length saturates; the byte that finds it full forces overflow.
    assign cnt_sat = (r_cnt == MAX_LEN);
    assign ph_eff  = cnt_sat ? PH_ERR : r_phase;
    assign err_eff = cnt_sat ? ST_OVERFLOW : r_err;
    assign hex     = hex_decode(i_data);

    // Verdict at the end of the line.
    always_comb begin
        if (err_eff != ST_OK) begin
            status = err_eff;
        end else begin
            unique case (ph_eff) inside
                PH_START: status = ST_NODOLLAR;
                PH_BODY:  status = ST_NOSTAR;
                PH_HEX1,
                PH_HEX2:  status = ST_BADHEX;
                default:  status = (r_xor == r_sum) ? ST_OK : ST_MISMATCH;
            endcase
        end
    end

    always_comb begin
        o_result.line_ok      = (status == ST_OK);
        o_result.status       = status;
        o_result.computed_sum = (status == ST_OK || status == ST_BADHEX ||
                                 status == ST_MISMATCH) ? r_xor : 8'h00;
        o_result.received_sum = (status == ST_OK || status == ST_MISMATCH) ? r_sum : 8'h00;
        o_result.line_length  = cnt_sat ? r_cnt : r_cnt + 1'b1;
    end

    // Next state of the line parser.
    always_comb begin
        n_phase = ph_eff;
        n_xor   = r_xor;
        n_sum   = r_sum;
        n_err   = err_eff;
        n_cnt   = cnt_sat ? r_cnt : r_cnt + 1'b1;
        if (is_nl) begin
            n_phase = PH_START;
            n_xor   = 8'h00;
            n_sum   = 8'h00;
            n_err   = ST_OK;
            n_cnt   = '0;
        end else begin
            unique case (ph_eff)
                PH_START: begin
                    if (i_data == CH_DOLLAR) begin
                        n_phase = PH_BODY;
                    end else begin
                        n_phase = PH_ERR;
                        n_err   = ST_NODOLLAR;
                    end
                end
                PH_BODY: begin
                    if (i_data == CH_STAR) begin
                        n_phase = PH_HEX1;
                    end else begin
                        n_xor = r_xor ^ i_data;
                    end
                end
                PH_HEX1: begin
                    if (hex[4]) begin
                        n_phase = PH_ERR;
                        n_err   = ST_BADHEX;
                    end else begin
                        n_sum   = {hex[3:0], 4'h0};
                        n_phase = PH_HEX2;
                    end
                end
                PH_HEX2: begin
                    if (hex[4]) begin
                        n_phase = PH_ERR;
                        n_err   = ST_BADHEX;
                    end else begin
                        n_sum   = {r_sum[7:4], hex[3:0]};
                        n_phase = PH_TAIL;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_xor   <= 8'h00;
            r_sum   <= 8'h00;
            r_err   <= ST_OK;
            r_cnt   <= '0;
        end else if (o_adv) begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_sum   <= n_sum;
            r_err   <= n_err;
            r_cnt   <= n_cnt;
        end
    end

    // The count never passes the saturation point.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_LEN)
        else $error("line count beyond saturation");

    // A sticky failure always parks the parser in the error phase.
    a_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK) |-> (r_phase == PH_ERR))
        else $error("failure code outside the error phase");

    // An overflow verdict reports the saturated length.
    a_ovf_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_fire && o_result.status == ST_OVERFLOW) |-> (o_result.line_length == MAX_LEN))
        else $error("overflow verdict with short length");

    // A delivered newline starts the next line from scratch.
    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fire |=> (r_cnt == '0 && r_phase == PH_START && r_xor == 8'h00))
        else $error("line state not cleared after newline");

endmodule

// File: rtl/nsc_out_stage.sv
module nsc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  nsc_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output nsc_pkg::t_result o_result
);
    import nsc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // The register can take a verdict when empty or being drained.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/nmea_sentence_checksum_check_core.sv
// NMEA sentence checker: bytes of the serial stream come in one per request on the
// slave side, and every newline yields one verdict request on the master side with
// the status, the computed and received checksums and the line length (saturated at
// the maximum line size). Bytes are taken one every clock cycle unless held back as
// below; a byte passes the input register and then the parsing logic, and a verdict
// is loaded into the result register as its newline leaves the input register. Only
// a newline can be held back, and only while the previous verdict still sits unread
// in the result register; the bytes behind it wait with it, and otherwise bytes flow
// at full rate regardless of the master side.
module nmea_sentence_checksum_check_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [7:0] rx_byte
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [0] line_ok, [3:1] status, [11:4] computed_sum, [19:12] received_sum,
    // [29:20] line_length, [31:30] zero
    output logic [nsc_pkg::OUT_W-1:0] m_axis_tdata
);
    import nsc_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       adv;
    logic       fire;
    logic       out_free;
    t_result    result;
    t_result    out_result;

    // Input register.
    nsc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .o_ready (s_axis_tready),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_data  (in_byte)
    );

    // Line parser and checksum compare.
    nsc_line_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_data     (in_byte),
        .i_out_free (out_free),
        .o_adv      (adv),
        .o_fire     (fire),
        .o_result   (result)
    );

    // Result register.
    nsc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (result),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    // Pack the verdict with zero padding on top.
    assign m_axis_tdata = {{(OUT_W - RES_W){1'b0}}, out_result};

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import nsc_pkg::*;

    // Cycles without any accepted request before the run is declared hung.
    localparam int unsigned STALL_LIMIT = 2000;
    // Stop adding random lines once this many bytes are queued.
    localparam int unsigned BYTES_GOAL = 2000;
    // Cycles to wait for stray verdicts once everything expected has arrived.
    localparam int unsigned TAIL_CYCLES = 20;

    // Parser phases of the checksum predictor.
    typedef enum logic [2:0] {
        AWAIT_DOLLAR, IN_BODY, HEX_HIGH, HEX_LOW, AFTER_SUM, SKIP_REST
    } t_parse;

    // Ways a generated sentence can be spoiled.
    typedef enum int unsigned {
        CLEAN, WRONG_SUM, LOWER_HEX, NOT_HEX, ONE_DIGIT, NO_DIGIT
    } t_flaw;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // [0] line_ok, [3:1] status, [11:4] computed_sum, [19:12] received_sum,
    // [29:20] line_length, [31:30] zero
    logic [OUT_W-1:0] m_axis_tdata;

    nmea_sentence_checksum_check_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state for the line being received.
    t_parse           parse_ph = AWAIT_DOLLAR;
    logic [7:0]       xor_acc  = 8'h00;
    logic [7:0]       sum_rx   = 8'h00;
    t_status          fault    = ST_OK;
    logic [LEN_W-1:0] line_len = '0;

    logic [7:0]  byte_q[$];
    t_result     verdict_q[$];
    int unsigned status_count[6] = '{default: 0};
    int unsigned bytes_total   = 0;
    int unsigned bytes_taken   = 0;
    int unsigned verdicts_seen = 0;
    int unsigned errors        = 0;
    int unsigned idle_cycles   = 0;
    int unsigned send_gap      = 0;
    int unsigned ready_hold    = 0;
    bit          send_quiet    = 1'b0;
    bit          recv_quiet    = 1'b0;
    logic        byte_done     = 1'b0;
    logic        verdict_done  = 1'b0;

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Value of an uppercase hex digit; bit 4 set when the byte is not one.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return 5'(c - 8'h30);
        end
        if (c >= "A" && c <= "F") begin
            return 5'(c - 8'h41 + 8'd10);
        end
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v) - 8'd10;
    endfunction

    // Sentence body byte: mostly printable, some arbitrary, now and then a dollar.
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do begin
            case ($urandom_range(0, 15))
                0:       b = CH_DOLLAR;
                1, 2, 3: b = 8'($urandom_range(0, 255));
                default: b = 8'($urandom_range(8'h20, 8'h7E));
            endcase
        end while (b == CH_NEWLINE || b == CH_STAR);
        return b;
    endfunction

    function automatic logic [7:0] bad_hex_byte();
        logic [7:0] b;
        logic [4:0] d;
        do begin
            b = 8'($urandom_range(0, 255));
            d = hex_digit(b);
        end while (!d[4] || b == CH_NEWLINE);
        return b;
    endfunction

    function automatic void push_text(input string s);
        foreach (s[i]) begin
            byte_q.push_back(s[i]);
        end
    endfunction

    // Queue one sentence with a body of the given length and the given flaw.
    function automatic void push_sentence(input int unsigned body_len, input t_flaw flaw,
                                          input bit with_tail);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] lo;
        sum = 8'h00;
        byte_q.push_back(CH_DOLLAR);
        repeat (body_len) begin
            b = body_byte();
            sum ^= b;
            byte_q.push_back(b);
        end
        byte_q.push_back(CH_STAR);
        if (flaw == WRONG_SUM) begin
            sum ^= 8'($urandom_range(1, 255));
        end
        hi = hex_char(sum[7:4]);
        lo = hex_char(sum[3:0]);
        if (flaw == LOWER_HEX) begin
            if ($urandom_range(0, 1) == 0) hi = 8'($urandom_range(8'h61, 8'h66));
            else lo = 8'($urandom_range(8'h61, 8'h66));
        end else if (flaw == NOT_HEX) begin
            if ($urandom_range(0, 1) == 0) hi = bad_hex_byte();
            else lo = bad_hex_byte();
        end
        if (flaw != NO_DIGIT) byte_q.push_back(hi);
        if (flaw != NO_DIGIT && flaw != ONE_DIGIT) byte_q.push_back(lo);
        // Trailing bytes after the checksum, each a carriage return or a body byte.
        if (with_tail) begin
            repeat ($urandom_range(0, 2)) begin
                byte_q.push_back(($urandom_range(0, 1) == 0) ? 8'h0D : body_byte());
            end
        end
        byte_q.push_back(CH_NEWLINE);
    endfunction

    task automatic clear_line();
        parse_ph = AWAIT_DOLLAR;
        xor_acc  = 8'h00;
        sum_rx   = 8'h00;
        fault    = ST_OK;
        line_len = '0;
    endtask

    // Advance the predictor by one byte; a newline queues the expected verdict.
    task automatic parse_byte(input logic [7:0] c);
        t_result    r;
        t_status    st;
        logic [4:0] d;
        if (line_len < MAX_LEN) begin
            line_len++;
        end else begin
            fault    = ST_OVERFLOW;
            parse_ph = SKIP_REST;
        end
        if (c == CH_NEWLINE) begin
            if (fault != ST_OK) begin
                st = fault;
            end else begin
                case (parse_ph)
                    AWAIT_DOLLAR:     st = ST_NODOLLAR;
                    IN_BODY:          st = ST_NOSTAR;
                    HEX_HIGH, HEX_LOW: st = ST_BADHEX;
                    default:          st = (xor_acc == sum_rx) ? ST_OK : ST_MISMATCH;
                endcase
            end
            r.line_ok      = (st == ST_OK);
            r.status       = st;
            r.computed_sum = (st == ST_OK || st == ST_BADHEX || st == ST_MISMATCH) ?
                             xor_acc : 8'h00;
            r.received_sum = (st == ST_OK || st == ST_MISMATCH) ? sum_rx : 8'h00;
            r.line_length  = line_len;
            verdict_q.push_back(r);
            status_count[int'(st)]++;
            clear_line();
        end else begin
            case (parse_ph)
                AWAIT_DOLLAR: begin
                    if (c == CH_DOLLAR) begin
                        parse_ph = IN_BODY;
                    end else begin
                        fault    = ST_NODOLLAR;
                        parse_ph = SKIP_REST;
                    end
                end
                IN_BODY: begin
                    if (c == CH_STAR) parse_ph = HEX_HIGH;
                    else xor_acc ^= c;
                end
                HEX_HIGH, HEX_LOW: begin
                    d = hex_digit(c);
                    if (d[4]) begin
                        fault    = ST_BADHEX;
                        parse_ph = SKIP_REST;
                    end else if (parse_ph == HEX_HIGH) begin
                        sum_rx   = {d[3:0], 4'h0};
                        parse_ph = HEX_LOW;
                    end else begin
                        sum_rx[3:0] = d[3:0];
                        parse_ph    = AFTER_SUM;
                    end
                end
                default: ;
            endcase
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= 40) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        end
    endfunction

    // Monitor: track accepted bytes and check every accepted verdict.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            byte_done    <= s_axis_tvalid && s_axis_tready;
            verdict_done <= m_axis_tvalid && m_axis_tready;
            // Compare first: a verdict can never belong to a newline taken at this edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[RES_W-1:0]);
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t: verdict with none expected, expected nothing, got %h",
                             $time, m_axis_tdata);
                end else begin
                    want = verdict_q.pop_front();
                    check_field("line_ok", want.line_ok, got.line_ok);
                    check_field("status", want.status, got.status);
                    check_field("computed_sum", want.computed_sum, got.computed_sum);
                    check_field("received_sum", want.received_sum, got.received_sum);
                    check_field("line_length", want.line_length, got.line_length);
                end
                check_field("padding", 0, m_axis_tdata[OUT_W-1:RES_W]);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata);
                bytes_taken++;
            end
            // Watchdog on handshake progress.
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    // Driver: present queued bytes with random gaps and stall the verdict side.
    always @(negedge i_clk) begin
        logic       next_valid;
        logic [7:0] next_data;
        if (i_rst_n) begin
            next_valid = s_axis_tvalid && !byte_done;
            next_data  = s_axis_tdata;
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (byte_q.size() > 0) begin
                    next_data  = byte_q.pop_front();
                    next_valid = 1'b1;
                    if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
                    send_gap = send_quiet ? 0 : $urandom_range(0, 4);
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= next_data;

            // The stall counts down only while a verdict is actually waiting.
            if (verdict_done) begin
                if ($urandom_range(0, 15) == 0) recv_quiet = !recv_quiet;
                ready_hold = recv_quiet ? 0 : $urandom_range(0, 4);
            end
            m_axis_tready <= (ready_hold == 0);
            if (ready_hold > 0 && m_axis_tvalid) ready_hold--;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned lines;
        int unsigned pick;
        logic [7:0]  b;
        lines = 0;
        clear_line();

        // Directed lines: empty line, extreme body bytes with a trailing carriage
        // return, newline after the first hex digit, lowercase hex, missing star and
        // a checksum mismatch.
        push_text("\n");
        byte_q.push_back(CH_DOLLAR);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        push_text("*FF\r\n");
        push_text("$*0\n");
        push_text("$*a0\n");
        push_text("$A\n");
        push_text("$*01\n");

        // Random lines, mostly well-formed sentences. Two long ones sit at the
        // overflow boundary: one exactly full, one a byte over with a bad hex digit.
        while (byte_q.size() < BYTES_GOAL) begin
            lines++;
            pick = $urandom_range(0, 99);
            if (lines == 10) begin
                push_sentence(MAX_LINE - 5, t_flaw'($urandom_range(0, 1)), 1'b0);
            end else if (lines == 60) begin
                push_sentence(MAX_LINE - 4, NOT_HEX, 1'b0);
            end else if (pick < 60) begin
                push_sentence($urandom_range(0, 12), CLEAN, 1'b1);
            end else if (pick < 80) begin
                push_sentence($urandom_range(0, 12), t_flaw'($urandom_range(1, 5)), 1'b1);
            end else if (pick < 90) begin
                repeat ($urandom_range(0, 12)) begin
                    do begin
                        b = 8'($urandom_range(0, 255));
                    end while (b == CH_NEWLINE);
                    byte_q.push_back(b);
                end
                byte_q.push_back(CH_NEWLINE);
            end else begin
                byte_q.push_back(CH_DOLLAR);
                repeat ($urandom_range(0, 12)) byte_q.push_back(body_byte());
                byte_q.push_back(CH_NEWLINE);
            end
        end
        bytes_total = byte_q.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken < bytes_total || verdict_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            errors++;
            $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
        end

        $display("Checked %0d verdicts over %0d bytes of sentences, noise and long lines.",
                 verdicts_seen, bytes_taken);
        $display("By status: ok %0d, no dollar %0d, no star %0d, bad hex %0d,",
                 status_count[0], status_count[1], status_count[2], status_count[3]);
        $display("           mismatch %0d, overflow %0d", status_count[4], status_count[5]);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/nsc_pkg.sv
rtl/nsc_in_stage.sv
rtl/nsc_line_check.sv
rtl/nsc_out_stage.sv
rtl/nmea_sentence_checksum_check_core.sv
tb/tb_top.sv
